>>> rtl/oscillator_freq_control_step_top_defines.svh
// Assertion macros for the checker module ofcs_chk.
`ifndef OSCILLATOR_FREQ_CONTROL_STEP_TOP_DEFINES_SVH
`define OSCILLATOR_FREQ_CONTROL_STEP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define OFCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OFCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ofcs_pkg.sv
package ofcs_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int FREQ_W = 16;
  localparam int CODE_W = 16;
  localparam int CMD_W  = 10;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 4;
  localparam int GAIN_W = 8;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [CMD_W-1:0]  CODE_MAX    = 10'd998;
  localparam logic [FREQ_W-1:0] LARGE_ERROR = 16'd500;
  localparam logic [GAIN_W-1:0] GAIN_VALUE  = 8'd220;

  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_HB_MIN   = 3'd1;
  localparam logic [2:0] REG_LOW_CNT  = 3'd2;
  localparam logic [2:0] REG_HIGH_CNT = 3'd3;
  localparam logic [2:0] REG_SINE     = 3'd4;

  typedef struct packed {
    logic              mode;
    logic [FREQ_W-1:0] measured_freq;
    logic              table_band;
    logic [IDX_W-1:0]  table_index;
    logic [FREQ_W-1:0] point_freq;
    logic [CODE_W-1:0] point_code;
  } in_word_t;

  typedef struct packed {
    logic [CMD_W-1:0]  freq_code;
    logic              cap_high;
    logic              cap_write;
    logic              gain_write;
    logic [GAIN_W-1:0] gain_code;
  } out_word_t;

  typedef struct packed {
    logic [FREQ_W-1:0] target_freq;
    logic [FREQ_W-1:0] high_band_min_freq;
    logic [CNT_W-1:0]  low_table_count;
    logic [CNT_W-1:0]  high_table_count;
    logic              sine_output;
  } cfg_t;

  typedef struct packed {
    logic load_wr;
    logic tick_start;
    logic rd;
    logic shift;
    logic take_code;
    logic mul;
    logic div_init;
    logic div_step;
    logic sum;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic need_interp;
    logic first;
    logic last;
    logic hit;
    logic div_done;
  } dp_stat_t;

endpackage

>>> rtl/oscillator_freq_control_step_top.sv
// Channel   Signals                          Word
// input     in_valid, in_stall, in_word      load point or control tick
// result    out_valid, out_stall, out_word   command, band, gain write (ticks only)
// config    psel/penable/pwrite/paddr/...    5 registers at 4*i
//
// Load word: written to the point table from idle. Tick with small error: step state,
// then the result register. Tick needing interpolation: the table walk (read + compare
// per point) until a segment is hit, then the multiply and the 32-step serial divider;
// the last point's code is taken when the walk ends with no segment hit.
// rst_n (sync, low) clears sequencer, command, band and config; tables have no reset.
// in_stall is high while a tick is in work; out_stall holds the result register
// and parks the sequencer before it loads the next result.
module oscillator_freq_control_step_top #(
  parameter int TABLE_DEPTH = ofcs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ofcs_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ofcs_pkg::out_word_t               out_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ofcs_pkg::APB_AW-1:0]       paddr,
  input  logic [ofcs_pkg::APB_DW-1:0]       pwdata,
  output logic [ofcs_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  ofcs_pkg::cfg_t      cfg_r;
  ofcs_pkg::ctrl_cmd_t cmd;
  ofcs_pkg::dp_stat_t  stat;
  ofcs_pkg::out_word_t result;
  ofcs_pkg::out_word_t out_word_r;
  logic                out_valid_r;
  logic                busy, out_free;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_freq        <= '0;
      cfg_r.high_band_min_freq <= '0;
      cfg_r.low_table_count    <= 5'd1;
      cfg_r.high_table_count   <= 5'd1;
      cfg_r.sine_output        <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        ofcs_pkg::REG_TARGET:   cfg_r.target_freq        <= pwdata[15:0];
        ofcs_pkg::REG_HB_MIN:   cfg_r.high_band_min_freq <= pwdata[15:0];
        ofcs_pkg::REG_LOW_CNT:  cfg_r.low_table_count    <= pwdata[4:0];
        ofcs_pkg::REG_HIGH_CNT: cfg_r.high_table_count   <= pwdata[4:0];
        ofcs_pkg::REG_SINE:     cfg_r.sine_output        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ofcs_pkg::REG_TARGET:   prdata = 32'(cfg_r.target_freq);
      ofcs_pkg::REG_HB_MIN:   prdata = 32'(cfg_r.high_band_min_freq);
      ofcs_pkg::REG_LOW_CNT:  prdata = 32'(cfg_r.low_table_count);
      ofcs_pkg::REG_HIGH_CNT: prdata = 32'(cfg_r.high_table_count);
      ofcs_pkg::REG_SINE:     prdata = 32'(cfg_r.sine_output);
      default:                prdata = '0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  ofcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  ofcs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_word (in_word),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r <= result;
    end
  end

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/ofcs_ctrl.sv
module ofcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  ofcs_pkg::dp_stat_t   stat,
  output ofcs_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_SUM   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.is_load) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.tick_start = 1'b1;
            state_nxt      = stat.need_interp ? S_RD : S_STEP;
          end
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_OUT;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!stat.first && stat.hit) begin
          cmd.mul   = 1'b1;
          state_nxt = S_DINIT;
        end else if (stat.last) begin
          cmd.take_code = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.shift = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/ofcs_dp.sv
module ofcs_dp #(
  parameter int TABLE_DEPTH = ofcs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ofcs_pkg::cfg_t       cfg,
  input  ofcs_pkg::in_word_t   in_word,
  input  ofcs_pkg::ctrl_cmd_t  cmd,
  output ofcs_pkg::dp_stat_t   stat,
  output ofcs_pkg::out_word_t  result
);

  localparam int MEM_DEPTH = 2 * TABLE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int KW        = $clog2(TABLE_DEPTH);
  localparam int FW        = ofcs_pkg::FREQ_W;
  localparam int CW        = ofcs_pkg::CODE_W;
  localparam int MW        = ofcs_pkg::CMD_W;

  // point tables, low band then high band
  logic [FW-1:0] freq_mem [MEM_DEPTH];
  logic [CW-1:0] code_mem [MEM_DEPTH];

  logic [FW-1:0] rd_freq_r, f0_r, meas_r;
  logic [CW-1:0] rd_code_r, c0_r;
  logic [KW-1:0] k_r, nlast;
  logic [MW-1:0] cmd_code_r;
  logic          band_r, cap_wr_r, gain_wr_r;

  logic signed [33:0] prod_r;
  logic signed [16:0] df_r;
  logic [31:0]        quo_r;
  logic [15:0]        den_r, rem_r;
  logic [4:0]         div_cnt_r;
  logic               q_neg_r, df_zero_r;

  logic [AW-1:0]      wa, ra;
  logic               wr_ok;
  logic [ofcs_pkg::CNT_W-1:0] cnt;
  logic               new_band;
  logic [FW-1:0]      err_in, err_st;
  logic [14:0]        half;
  logic [15:0]        up_sum;
  logic [MW-1:0]      step_code, rd_code_sat, sum_code;
  logic signed [16:0] d_t, d_c;
  logic [33:0]        prod_neg;
  logic [16:0]        df_neg;
  logic [16:0]        rem_sh;
  logic               ge;
  logic signed [33:0] q34, s34;

  // table write / read
  assign wr_ok = int'(in_word.table_index) < TABLE_DEPTH;
  assign wa = in_word.table_band ? AW'(TABLE_DEPTH) + AW'(in_word.table_index)
                                 : AW'(in_word.table_index);
  assign ra = band_r ? AW'(TABLE_DEPTH) + AW'(k_r) : AW'(k_r);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_ok) begin
      freq_mem[wa] <= in_word.point_freq;
      code_mem[wa] <= in_word.point_code;
    end
    if (cmd.rd) begin
      rd_freq_r <= freq_mem[ra];
      rd_code_r <= code_mem[ra];
    end
  end

  // tick decision
  assign new_band = cfg.target_freq >= cfg.high_band_min_freq;
  assign err_in = (in_word.measured_freq >= cfg.target_freq)
                ? in_word.measured_freq - cfg.target_freq
                : cfg.target_freq - in_word.measured_freq;

  // point count clamp
  assign cnt = band_r ? cfg.high_table_count : cfg.low_table_count;
  always_comb begin
    if (cnt == '0) begin
      nlast = '0;
    end else if (int'(cnt) > TABLE_DEPTH) begin
      nlast = KW'(TABLE_DEPTH - 1);
    end else begin
      nlast = KW'(cnt - 5'd1);
    end
  end

  // small-error step
  assign err_st = (meas_r >= cfg.target_freq) ? meas_r - cfg.target_freq
                                              : cfg.target_freq - meas_r;
  assign half   = err_st[15:1];
  assign up_sum = 16'(cmd_code_r) + 16'(half);
  always_comb begin
    if (meas_r < cfg.target_freq) begin
      step_code = (up_sum > 16'(ofcs_pkg::CODE_MAX)) ? ofcs_pkg::CODE_MAX : up_sum[MW-1:0];
    end else if (16'(half) > 16'(cmd_code_r)) begin
      step_code = '0;
    end else begin
      step_code = cmd_code_r - MW'(half);
    end
  end

  assign rd_code_sat = (rd_code_r > 16'(ofcs_pkg::CODE_MAX)) ? ofcs_pkg::CODE_MAX
                                                            : rd_code_r[MW-1:0];

  // segment terms
  assign d_t      = $signed({1'b0, cfg.target_freq}) - $signed({1'b0, f0_r});
  assign d_c      = $signed({1'b0, rd_code_r}) - $signed({1'b0, c0_r});
  assign prod_neg = -prod_r;
  assign df_neg   = -df_r;

  // radix-2 restoring divider
  assign rem_sh = {rem_r, quo_r[31]};
  assign ge     = rem_sh >= {1'b0, den_r};

  assign q34 = df_zero_r ? '0 : (q_neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r}));
  assign s34 = $signed({18'd0, c0_r}) + q34;
  always_comb begin
    if (s34[33]) begin
      sum_code = '0;
    end else if (s34 > $signed(34'(ofcs_pkg::CODE_MAX))) begin
      sum_code = ofcs_pkg::CODE_MAX;
    end else begin
      sum_code = s34[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_code_r <= '0;
      band_r     <= 1'b0;
      cap_wr_r   <= 1'b0;
      gain_wr_r  <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        band_r    <= new_band;
        cap_wr_r  <= new_band != band_r;
        gain_wr_r <= 1'b0;
      end
      if (cmd.step) begin
        cmd_code_r <= step_code;
        gain_wr_r  <= cfg.sine_output;
      end
      if (cmd.take_code) begin
        cmd_code_r <= rd_code_sat;
      end
      if (cmd.sum) begin
        cmd_code_r <= sum_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      meas_r <= in_word.measured_freq;
      k_r    <= '0;
    end
    if (cmd.shift) begin
      f0_r <= rd_freq_r;
      c0_r <= rd_code_r;
      k_r  <= k_r + KW'(1);
    end
    if (cmd.mul) begin
      prod_r <= d_t * d_c;
      df_r   <= $signed({1'b0, rd_freq_r}) - $signed({1'b0, f0_r});
    end
    if (cmd.div_init) begin
      quo_r     <= prod_r[33] ? prod_neg[31:0] : prod_r[31:0];
      den_r     <= df_r[16] ? df_neg[15:0] : df_r[15:0];
      q_neg_r   <= prod_r[33] ^ df_r[16];
      df_zero_r <= (df_r == '0);
      rem_r     <= '0;
      div_cnt_r <= 5'd31;
    end
    if (cmd.div_step) begin
      rem_r     <= ge ? 16'(rem_sh - {1'b0, den_r}) : rem_sh[15:0];
      quo_r     <= {quo_r[30:0], ge};
      div_cnt_r <= div_cnt_r - 5'd1;
    end
  end

  assign stat.is_load     = in_word.mode;
  assign stat.need_interp = (new_band != band_r) || (err_in > ofcs_pkg::LARGE_ERROR);
  assign stat.first       = (k_r == '0);
  assign stat.last        = (k_r == nlast);
  assign stat.hit         = cfg.target_freq <= rd_freq_r;
  assign stat.div_done    = (div_cnt_r == '0);

  assign result.freq_code  = cmd_code_r;
  assign result.cap_high   = band_r;
  assign result.cap_write  = cap_wr_r;
  assign result.gain_write = gain_wr_r;
  assign result.gain_code  = gain_wr_r ? ofcs_pkg::GAIN_VALUE : '0;

endmodule

>>> rtl/ofcs_chk.sv
`include "oscillator_freq_control_step_top_defines.svh"

module ofcs_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ofcs_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input ofcs_pkg::out_word_t out_word
);

  `OFCS_ASSERT_NXT(a_tick_busy, in_valid && !in_stall && !in_word.mode, in_stall, "tick accepted but input not stalled")
  `OFCS_ASSERT_NXT(a_load_silent, in_valid && !in_stall && in_word.mode && !out_valid, !out_valid, "load word produced a result")
  `OFCS_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(in_stall), "result appeared without work in progress")
  `OFCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result dropped or changed")

endmodule

bind oscillator_freq_control_step_top ofcs_chk u_ofcs_chk (.*);
